FILE: design/lru_page_buffer_with_pinning_defines.svh
// assertion macros for the lru page buffer
// used by files that carry concurrent checks; no other dependencies
`ifndef LRU_PAGE_BUFFER_WITH_PINNING_DEFINES_SVH
`define LRU_PAGE_BUFFER_WITH_PINNING_DEFINES_SVH
`ifndef SYNTHESIS
`define LPB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define LPB_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPB_ASSERT(lbl, clk, rstn, prop, msg)
`define LPB_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: design/lpb_pkg.sv
// shared constants, codes and types of the lru page buffer
// no dependencies
`default_nettype none
package lpb_pkg;
    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int PIN_BITS = 16;
    localparam int PAGE_W   = 32;
    localparam int CNT_W    = 5;

    localparam logic [2:0] OP_GET   = 3'd0;
    localparam logic [2:0] OP_DIRTY = 3'd1;
    localparam logic [2:0] OP_PIN   = 3'd2;
    localparam logic [2:0] OP_UNPIN = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;
    localparam logic [2:0] OP_STATS = 3'd5;

    localparam logic [1:0] RK_DONE  = 2'd0;
    localparam logic [1:0] RK_WB    = 2'd1;
    localparam logic [1:0] RK_READ  = 2'd2;
    localparam logic [1:0] RK_SYNC  = 2'd3;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOPAGE = 2'd1;
    localparam logic [1:0] STS_NOEVICT = 2'd2;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_CLEAN   = 2'd1;
    localparam logic [1:0] ST_DIRTY   = 2'd2;

    typedef enum logic [2:0] {
        TOP_NONE, TOP_PROMOTE_PIN, TOP_DIRTY, TOP_PIN,
        TOP_UNPIN, TOP_CLEAN, TOP_DROP, TOP_INSTALL
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op             op;
        logic [PAGE_W-1:0]   page;
    } t_tbl_cmd;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic                pinned;
        logic [SLOT_W-1:0]   rank;
        logic [PAGE_W-1:0]   tag;
    } t_tbl_rd;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic [PAGE_W-1:0]   page;
        logic [SLOT_W-1:0]   slot;
        logic                last;
        logic [CNT_W-1:0]    cached;
        logic [CNT_W-1:0]    dirty;
        logic [CNT_W-1:0]    pinned;
    } t_result;
endpackage
`default_nettype wire

FILE: design/lpb_if.sv
// request and result channel interfaces of the lru page buffer
// depends on lpb_pkg for field widths
`default_nettype none
interface lpb_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                operation;
    logic [lpb_pkg::PAGE_W-1:0] page_number;
    modport source (output valid, output operation, output page_number, input ready);
    modport sink   (input valid, input operation, input page_number, output ready);
endinterface

interface lpb_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 result_kind;
    logic [1:0]                 status;
    logic [lpb_pkg::PAGE_W-1:0] page_out;
    logic [lpb_pkg::SLOT_W-1:0] slot;
    logic                       last;
    logic [lpb_pkg::CNT_W-1:0]  cached_count;
    logic [lpb_pkg::CNT_W-1:0]  dirty_slots;
    logic [lpb_pkg::CNT_W-1:0]  pinned_slots;
    modport source (output valid, output result_kind, output status, output page_out,
                    output slot, output last, output cached_count, output dirty_slots,
                    output pinned_slots, input ready);
    modport sink   (input valid, input result_kind, input status, input page_out,
                    input slot, input last, input cached_count, input dirty_slots,
                    input pinned_slots, output ready);
endinterface
`default_nettype wire

FILE: design/lpb_table.sv
// page-frame table: tags, entry status, pin counts, recency ranks, valid total
// depends on lpb_pkg; one slot is read and updated per cycle at i_idx, though rank updates also touch other live slots
`default_nettype none
module lpb_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [lpb_pkg::SLOT_W-1:0]  i_idx,
    input  wire lpb_pkg::t_tbl_cmd           i_cmd,
    output lpb_pkg::t_tbl_rd                 o_rd,
    output logic [lpb_pkg::CNT_W-1:0]        o_valid_total
);
    logic [lpb_pkg::PAGE_W-1:0]   r_tag  [lpb_pkg::SLOTS];
    logic [1:0]                   r_st   [lpb_pkg::SLOTS];
    logic [lpb_pkg::PIN_BITS-1:0] r_pin  [lpb_pkg::SLOTS];
    logic [lpb_pkg::SLOT_W-1:0]   r_rank [lpb_pkg::SLOTS];
    logic [lpb_pkg::CNT_W-1:0]    r_total;

    logic [lpb_pkg::SLOT_W-1:0]   sel_rank;
    logic [lpb_pkg::PIN_BITS-1:0] sel_pin;
    logic                         pin_full;

    assign sel_rank = r_rank[i_idx];
    assign sel_pin  = r_pin[i_idx];
    assign pin_full = (sel_pin == {lpb_pkg::PIN_BITS{1'b1}});

    assign o_rd.valid  = (r_st[i_idx] != lpb_pkg::ST_INVALID);
    assign o_rd.dirty  = (r_st[i_idx] == lpb_pkg::ST_DIRTY);
    assign o_rd.pinned = (sel_pin != '0);
    assign o_rd.rank   = sel_rank;
    assign o_rd.tag    = r_tag[i_idx];
    assign o_valid_total = r_total;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lpb_pkg::TOP_INSTALL) begin
            r_tag[i_idx] <= i_cmd.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < lpb_pkg::SLOTS; j++) begin
                r_st[j]   <= lpb_pkg::ST_INVALID;
                r_pin[j]  <= '0;
                r_rank[j] <= '0;
            end
            r_total <= '0;
        end else begin
            unique case (i_cmd.op)
                lpb_pkg::TOP_PROMOTE_PIN: begin
                    for (int j = 0; j < lpb_pkg::SLOTS; j++) begin
                        if (r_st[j] != lpb_pkg::ST_INVALID && r_rank[j] < sel_rank) begin
                            r_rank[j] <= r_rank[j] + 1'b1;
                        end
                    end
                    r_rank[i_idx] <= '0;
                    if (!pin_full) r_pin[i_idx] <= sel_pin + 1'b1;
                end
                lpb_pkg::TOP_DIRTY: r_st[i_idx] <= lpb_pkg::ST_DIRTY;
                lpb_pkg::TOP_PIN: begin
                    if (!pin_full) r_pin[i_idx] <= sel_pin + 1'b1;
                end
                lpb_pkg::TOP_UNPIN: begin
                    if (sel_pin != '0) r_pin[i_idx] <= sel_pin - 1'b1;
                end
                lpb_pkg::TOP_CLEAN: r_st[i_idx] <= lpb_pkg::ST_CLEAN;
                lpb_pkg::TOP_DROP: begin
                    for (int j = 0; j < lpb_pkg::SLOTS; j++) begin
                        if (lpb_pkg::SLOT_W'(j) != i_idx && r_st[j] != lpb_pkg::ST_INVALID
                            && r_rank[j] > sel_rank) begin
                            r_rank[j] <= r_rank[j] - 1'b1;
                        end
                    end
                    r_st[i_idx]   <= lpb_pkg::ST_INVALID;
                    r_pin[i_idx]  <= '0;
                    r_rank[i_idx] <= '0;
                    if (r_total != '0) r_total <= r_total - 1'b1;
                end
                lpb_pkg::TOP_INSTALL: begin
                    // every live entry ages by one, rank wraps at the slot width
                    for (int j = 0; j < lpb_pkg::SLOTS; j++) begin
                        if (r_st[j] != lpb_pkg::ST_INVALID) begin
                            r_rank[j] <= r_rank[j] + 1'b1;
                        end
                    end
                    r_st[i_idx]   <= lpb_pkg::ST_CLEAN;
                    r_pin[i_idx]  <= lpb_pkg::PIN_BITS'(1);
                    r_rank[i_idx] <= '0;
                    r_total       <= r_total + 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/lru_page_buffer_with_pinning.sv
// top level of the lru page buffer: sequencer, slot scan and result register
// depends on lpb_pkg, lpb_if, lpb_table and the assertion macro header
//
// channel   dir  handshake         payload
// i_in      in   valid/ready       operation, page_number
// o_out     out  valid/ready       result_kind, status, page_out, slot, last, counts
// i_cfg     in   i_cfg_we          i_cfg_data (active_entries)
//
// an operation is accepted while idle, walks each active slot through the shared compare, then finishes
// a get miss goes on from the finish through a read step and a done step
// every result step, scan flush writebacks too, holds while a full result register is unread
// i_in.ready is high only while idle; a result may wait in the register meanwhile
// synchronous active-low reset empties the table at once, no clearing pass
`default_nettype none
`include "lru_page_buffer_with_pinning_defines.svh"
module lru_page_buffer_with_pinning (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lpb_in_if.sink                          i_in,
    lpb_out_if.source                       o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [lpb_pkg::CNT_W-1:0]  i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_FIN  = 5'b00100,
        S_RD   = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam int SW = lpb_pkg::SLOT_W;
    localparam int CW = lpb_pkg::CNT_W;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_active;
    logic [2:0]                 r_op, n_op;
    logic [lpb_pkg::PAGE_W-1:0] r_page, n_page;
    logic [SW-1:0]              r_idx, n_idx;
    logic                       r_hit, n_hit;
    logic [SW-1:0]              r_hit_idx, n_hit_idx;
    logic                       r_free, n_free;
    logic [SW-1:0]              r_free_idx, n_free_idx;
    logic                       r_vic, n_vic;
    logic [SW-1:0]              r_vic_idx, n_vic_idx;
    logic [SW-1:0]              r_vic_rank, n_vic_rank;
    logic                       r_vic_dirty, n_vic_dirty;
    logic [lpb_pkg::PAGE_W-1:0] r_vic_tag, n_vic_tag;
    logic [CW-1:0]              r_dcnt, n_dcnt;
    logic [CW-1:0]              r_pcnt, n_pcnt;
    logic [SW-1:0]              r_tgt, n_tgt;
    logic                       r_ov, n_ov;
    lpb_pkg::t_result           r_res, n_res;

    logic [CW-1:0]              lim;
    logic                       scan_end;
    logic                       can_push;
    logic                       push;
    logic [SW-1:0]              tbl_idx;
    lpb_pkg::t_tbl_cmd          tbl_cmd;
    lpb_pkg::t_tbl_rd           rd;
    logic [CW-1:0]              valid_total;

    lpb_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_idx         (tbl_idx),
        .i_cmd         (tbl_cmd),
        .o_rd          (rd),
        .o_valid_total (valid_total)
    );

    // zero acts as one, anything above the table size as the table size
    always_comb begin
        priority if (r_active == '0) lim = CW'(1);
        else if (r_active > CW'(lpb_pkg::SLOTS)) lim = CW'(lpb_pkg::SLOTS);
        else lim = r_active;
    end

    assign scan_end = ({1'b0, r_idx} == CW'(lim - 1'b1));
    assign can_push = !r_ov || o_out.ready;

    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign o_out.valid        = r_ov;
    assign o_out.result_kind  = r_res.kind;
    assign o_out.status       = r_res.status;
    assign o_out.page_out     = r_res.page;
    assign o_out.slot         = r_res.slot;
    assign o_out.last         = r_res.last;
    assign o_out.cached_count = r_res.cached;
    assign o_out.dirty_slots  = r_res.dirty;
    assign o_out.pinned_slots = r_res.pinned;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_page      = r_page;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_vic       = r_vic;
        n_vic_idx   = r_vic_idx;
        n_vic_rank  = r_vic_rank;
        n_vic_dirty = r_vic_dirty;
        n_vic_tag   = r_vic_tag;
        n_dcnt      = r_dcnt;
        n_pcnt      = r_pcnt;
        n_tgt       = r_tgt;
        push        = 1'b0;
        n_res       = '0;
        tbl_cmd.op  = lpb_pkg::TOP_NONE;
        tbl_cmd.page = r_page;
        tbl_idx     = r_tgt;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op     = i_in.operation;
                    n_page   = i_in.page_number;
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_vic    = 1'b0;
                    n_dcnt   = '0;
                    n_pcnt   = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                tbl_idx = r_idx;
                // a dirty slot under flush needs the result register, else hold
                if (!(r_op == lpb_pkg::OP_FLUSH && rd.dirty && !can_push)) begin
                    if (rd.valid && rd.tag == r_page && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_idx;
                    end
                    if (!rd.valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_idx;
                    end
                    if (rd.valid && !rd.pinned && (!r_vic || rd.rank > r_vic_rank)) begin
                        n_vic       = 1'b1;
                        n_vic_idx   = r_idx;
                        n_vic_rank  = rd.rank;
                        n_vic_dirty = rd.dirty;
                        n_vic_tag   = rd.tag;
                    end
                    if (rd.dirty) n_dcnt = r_dcnt + 1'b1;
                    if (rd.valid && rd.pinned) n_pcnt = r_pcnt + 1'b1;
                    if (r_op == lpb_pkg::OP_FLUSH && rd.dirty) begin
                        push       = 1'b1;
                        n_res.kind = lpb_pkg::RK_WB;
                        n_res.page = rd.tag;
                        n_res.slot = r_idx;
                        tbl_cmd.op = lpb_pkg::TOP_CLEAN;
                    end
                    if (scan_end) n_state = S_FIN;
                    else n_idx = r_idx + 1'b1;
                end
            end
            S_FIN: begin
                priority if (r_hit) tbl_idx = r_hit_idx;
                else if (r_free) tbl_idx = r_free_idx;
                else tbl_idx = r_vic_idx;
                if (can_push) begin
                    n_state    = S_IDLE;
                    n_res.last = 1'b1;
                    unique case (r_op)
                        lpb_pkg::OP_GET: begin
                            priority if (r_hit) begin
                                push       = 1'b1;
                                n_res.page = r_page;
                                n_res.slot = r_hit_idx;
                                tbl_cmd.op = lpb_pkg::TOP_PROMOTE_PIN;
                            end else if (r_free) begin
                                n_tgt   = r_free_idx;
                                n_state = S_RD;
                            end else if (r_vic) begin
                                n_tgt      = r_vic_idx;
                                n_state    = S_RD;
                                tbl_cmd.op = lpb_pkg::TOP_DROP;
                                n_res.last = 1'b0;
                                if (r_vic_dirty) begin
                                    push       = 1'b1;
                                    n_res.kind = lpb_pkg::RK_WB;
                                    n_res.page = r_vic_tag;
                                    n_res.slot = r_vic_idx;
                                end
                            end else begin
                                push         = 1'b1;
                                n_res.status = lpb_pkg::STS_NOEVICT;
                                n_res.page   = r_page;
                            end
                        end
                        lpb_pkg::OP_DIRTY, lpb_pkg::OP_PIN, lpb_pkg::OP_UNPIN: begin
                            push = 1'b1;
                            if (!r_hit) begin
                                n_res.status = lpb_pkg::STS_NOPAGE;
                            end else begin
                                unique case (r_op)
                                    lpb_pkg::OP_DIRTY: tbl_cmd.op = lpb_pkg::TOP_DIRTY;
                                    lpb_pkg::OP_PIN:   tbl_cmd.op = lpb_pkg::TOP_PIN;
                                    default:           tbl_cmd.op = lpb_pkg::TOP_UNPIN;
                                endcase
                            end
                        end
                        lpb_pkg::OP_FLUSH: begin
                            push       = 1'b1;
                            n_res.kind = lpb_pkg::RK_SYNC;
                        end
                        lpb_pkg::OP_STATS: begin
                            push         = 1'b1;
                            n_res.cached = valid_total;
                            n_res.dirty  = r_dcnt;
                            n_res.pinned = r_pcnt;
                        end
                        default: push = 1'b1;
                    endcase
                end
            end
            S_RD: begin
                if (can_push) begin
                    push       = 1'b1;
                    n_res.kind = lpb_pkg::RK_READ;
                    n_res.page = r_page;
                    n_res.slot = r_tgt;
                    tbl_cmd.op = lpb_pkg::TOP_INSTALL;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (can_push) begin
                    push       = 1'b1;
                    n_res.page = r_page;
                    n_res.slot = r_tgt;
                    n_res.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (push) n_ov = 1'b1;
        else if (o_out.ready) n_ov = 1'b0;
        else n_ov = r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= CW'(lpb_pkg::SLOTS);
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) r_active <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_page      <= n_page;
        r_idx       <= n_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_vic       <= n_vic;
        r_vic_idx   <= n_vic_idx;
        r_vic_rank  <= n_vic_rank;
        r_vic_dirty <= n_vic_dirty;
        r_vic_tag   <= n_vic_tag;
        r_dcnt      <= n_dcnt;
        r_pcnt      <= n_pcnt;
        r_tgt       <= n_tgt;
        if (push) r_res <= n_res;
    end

    `LPB_ASSERT(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> ({1'b0, r_idx} < lim), "scan index beyond active slots")
    `LPB_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state != S_IDLE), "accepted request did not start")
    `LPB_ASSERT(a_total_bound, i_clk, i_rst_n, valid_total <= CW'(lpb_pkg::SLOTS), "valid total above table size")
    `LPB_ASSERT(a_mid_result_busy, i_clk, i_rst_n, (o_out.valid && o_out.ready && !o_out.last && r_state == S_IDLE) |-> 1'b0, "non-final result left while idle")
endmodule
`default_nettype wire
